// ===== hw/rtl/khfm_pkg.sv =====
// Shared types and constants for the kernel heap frame mapper.
// Used by khfm_frame_map and kernel_heap_frame_mapper_top; no dependencies.
package khfm_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_COLLIDE = 2'd1;
  localparam logic [1:0] STATUS_NOFRAME = 2'd2;

  localparam logic [1:0] CFG_STACK_BASE = 2'd0;
  localparam logic [1:0] CFG_PAGING     = 2'd1;
  localparam logic [1:0] CFG_HEAP_START = 2'd2;
  localparam logic [1:0] CFG_RESERVED   = 2'd3;

  // Result of the first-free search over one row of the frame map
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } khfm_find_t;

endpackage

// ===== hw/rtl/khfm_frame_map.sv =====
// Frame usage bitmap held as rows of 32 bits, with the first-free search over the row read.
// Depends on khfm_pkg.
module khfm_frame_map #(
  parameter int FRAME_COUNT = 512,
  localparam int Rows = (FRAME_COUNT + khfm_pkg::WORD_BITS - 1) / khfm_pkg::WORD_BITS,
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  logic                              clk,
  input  logic [RowW-1:0]                   rd_addr,
  output logic [khfm_pkg::WORD_BITS-1:0]    rd_data,
  input  logic                              wr_en,
  input  logic [RowW-1:0]                   wr_addr,
  input  logic [khfm_pkg::WORD_BITS-1:0]    wr_data,
  input  logic [9:0]                        reserved_frames,
  output khfm_pkg::khfm_find_t              find
);

  localparam int LastBits = FRAME_COUNT - (Rows - 1) * khfm_pkg::WORD_BITS;

  logic [khfm_pkg::WORD_BITS-1:0] mem [Rows];
  logic [RowW-1:0]                row_q;
  logic [khfm_pkg::WORD_BITS-1:0] avail;
  logic [khfm_pkg::BIT_W-1:0]     lo;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    row_q   <= rd_addr;
  end

  // Frames below the reserved count are masked only in the row the scan starts at; lower rows are never scanned
  always_comb begin
    lo = '0;
    if (16'(row_q) == 16'(reserved_frames[9:5])) begin
      lo = reserved_frames[4:0];
    end
    for (int b = 0; b < khfm_pkg::WORD_BITS; b++) begin
      avail[b] = !rd_data[b] && (khfm_pkg::BIT_W'(b) >= lo) &&
                 ((32'(row_q) != Rows - 1) || (b < LastBits));
    end
  end

  always_comb begin
    find.found = |avail;
    find.pos   = '0;
    for (int b = khfm_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        find.pos = khfm_pkg::BIT_W'(b);
      end
    end
  end

endmodule

// ===== hw/rtl/khfm_page_table.sv =====
// Page table: per-page valid bit and mapped frame number, each a memory.
// No package dependencies.
module khfm_page_table #(
  parameter int TABLE_PAGES = 128,
  parameter int FRAME_COUNT = 512,
  localparam int PageW  = $clog2(TABLE_PAGES),
  localparam int FrameW = $clog2(FRAME_COUNT)
) (
  input  logic              clk,
  input  logic [PageW-1:0]  rd_addr,
  output logic              rd_valid,
  output logic [FrameW-1:0] rd_frame,
  input  logic [PageW-1:0]  wr_addr,
  input  logic              valid_we,
  input  logic              valid_wd,
  input  logic              frame_we,
  input  logic [FrameW-1:0] frame_wd
);

  logic              valid_mem [TABLE_PAGES];
  logic [FrameW-1:0] frame_mem [TABLE_PAGES];

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[wr_addr] <= valid_wd;
    end
    rd_valid <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[wr_addr] <= frame_wd;
    end
    rd_frame <= frame_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/kernel_heap_frame_mapper_top.sv =====
// Kernel heap break mapper: sequencer over the frame bitmap and page table.
// Rejected requests, paging off or an unchanged break go from the check state to the result;
// growth reads and checks a bitmap row per new page and per full row passed over; shrinking
// or undoing reads each page's entry and writes back each valid one. Busy holds until the
// result cycle ends, so the next request is taken in the cycle after it at the earliest.
// Reset clears max(ceil(FRAME_COUNT/32), TABLE_PAGES) entries (128 by default) under busy.
module kernel_heap_frame_mapper_top #(
  parameter int FRAME_COUNT = 512,
  parameter int TABLE_PAGES = 128,
  parameter int PAGE_SHIFT  = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] new_break_addr,
  output logic        done,
  output logic [1:0]  status,
  output logic [6:0]  break_page_now,
  output logic        flush_request,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int Rows   = (FRAME_COUNT + khfm_pkg::WORD_BITS - 1) / khfm_pkg::WORD_BITS;
  localparam int RowW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int IdxW   = RowW + khfm_pkg::BIT_W;
  localparam int FrameW = $clog2(FRAME_COUNT);
  localparam int PageW  = $clog2(TABLE_PAGES);
  localparam int ClrLen = (Rows > TABLE_PAGES) ? Rows : TABLE_PAGES;
  localparam int ClrW   = $clog2(ClrLen);
  localparam logic [32:0] PageMask = (33'd1 << PAGE_SHIFT) - 33'd1;

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CHECK    = 9'b000000100,
    S_SCAN_RD  = 9'b000001000,
    S_SCAN_CHK = 9'b000010000,
    S_FREE_RD  = 9'b000100000,
    S_FREE_FRM = 9'b001000000,
    S_FREE_WR  = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;
  logic [ClrW-1:0] clr_cnt;

  logic [6:0] stack_base;
  logic       paging;
  logic [9:0] reserved;
  logic [6:0] break_page;

  logic [31:0] addr_q;
  logic [6:0]  np_q;
  logic [6:0]  pg;
  logic [6:0]  pg_end;
  logic        shrink;
  logic [RowW-1:0] scan_row;
  logic [1:0]  status_q;
  logic        flush_q;

  // Request decode
  logic [32:0] want;
  logic        collide;
  logic [15:0] res_row;
  logic [6:0]  pg_inc;

  // Frame map
  logic [RowW-1:0]                fm_rd_addr;
  logic [khfm_pkg::WORD_BITS-1:0] fm_rd_data;
  logic                           fm_wr_en;
  logic [RowW-1:0]                fm_wr_addr;
  logic [khfm_pkg::WORD_BITS-1:0] fm_wr_data;
  khfm_pkg::khfm_find_t           find;

  // Page table
  logic [PageW-1:0]  pt_addr;
  logic [PageW-1:0]  pt_wr_addr;
  logic              pt_rd_valid;
  logic [FrameW-1:0] pt_rd_frame;
  logic              pt_valid_we;
  logic              pt_valid_wd;
  logic              pt_frame_we;
  logic [FrameW-1:0] pt_frame_wd;

  logic [PageW+6:0]  pg_wide;
  logic [IdxW-1:0]   fr_wide;
  logic [IdxW-1:0]   new_idx;
  logic [khfm_pkg::WORD_BITS-1:0] set_mask;
  logic [khfm_pkg::WORD_BITS-1:0] clr_mask;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign status        = status_q;
  assign flush_request = flush_q;
  assign break_page_now = break_page;

  assign want    = ({1'b0, addr_q} + PageMask) >> PAGE_SHIFT;
  assign collide = (want >= 33'(stack_base)) || (want >= 33'(TABLE_PAGES));
  assign res_row = 16'(reserved[9:5]);
  assign pg_inc  = pg + 7'd1;

  assign pg_wide  = {{PageW{1'b0}}, pg};
  assign pt_addr  = pg_wide[PageW-1:0];
  assign fr_wide  = IdxW'(pt_rd_frame);
  assign new_idx  = {scan_row, find.pos};
  assign set_mask = khfm_pkg::WORD_BITS'(1) << find.pos;
  assign clr_mask = khfm_pkg::WORD_BITS'(1) << fr_wide[khfm_pkg::BIT_W-1:0];

  always_comb begin
    fm_rd_addr  = fr_wide[IdxW-1:khfm_pkg::BIT_W];
    fm_wr_en    = 1'b0;
    fm_wr_addr  = fr_wide[IdxW-1:khfm_pkg::BIT_W];
    fm_wr_data  = fm_rd_data & ~clr_mask;
    pt_wr_addr  = pt_addr;
    pt_valid_we = 1'b0;
    pt_valid_wd = 1'b0;
    pt_frame_we = 1'b0;
    pt_frame_wd = new_idx[FrameW-1:0];
    unique case (state)
      S_CLEAR: begin
        fm_wr_en    = (32'(clr_cnt) < Rows);
        fm_wr_addr  = clr_cnt[RowW-1:0];
        fm_wr_data  = '0;
        pt_wr_addr  = clr_cnt[PageW-1:0];
        pt_valid_we = (32'(clr_cnt) < TABLE_PAGES);
      end
      S_SCAN_RD: begin
        fm_rd_addr = scan_row;
      end
      S_SCAN_CHK: begin
        if (find.found) begin
          fm_wr_en    = 1'b1;
          fm_wr_addr  = scan_row;
          fm_wr_data  = fm_rd_data | set_mask;
          pt_valid_we = 1'b1;
          pt_valid_wd = 1'b1;
          pt_frame_we = 1'b1;
        end
      end
      S_FREE_WR: begin
        fm_wr_en    = 1'b1;
        pt_valid_we = 1'b1;
      end
      S_IDLE, S_CHECK, S_FREE_RD, S_FREE_FRM, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      stack_base <= 7'd126;
      paging     <= 1'b0;
      reserved   <= '0;
      break_page <= '0;
      status_q   <= khfm_pkg::STATUS_OK;
      flush_q    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          khfm_pkg::CFG_STACK_BASE: stack_base <= cfg_data[6:0];
          khfm_pkg::CFG_PAGING:     paging     <= cfg_data[0];
          khfm_pkg::CFG_HEAP_START: break_page <= cfg_data[6:0];
          khfm_pkg::CFG_RESERVED:   reserved   <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ClrW'(1);
          if (32'(clr_cnt) == ClrLen - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            addr_q <= new_break_addr;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          np_q <= want[6:0];
          if (collide) begin
            status_q <= khfm_pkg::STATUS_COLLIDE;
            flush_q  <= 1'b0;
            state    <= S_DONE;
          end else if (!paging) begin
            break_page <= want[6:0];
            status_q   <= khfm_pkg::STATUS_OK;
            flush_q    <= 1'b0;
            state      <= S_DONE;
          end else begin
            flush_q  <= 1'b1;
            status_q <= khfm_pkg::STATUS_OK;
            if (want[6:0] > break_page) begin
              pg       <= break_page;
              pg_end   <= want[6:0];
              scan_row <= res_row[RowW-1:0];
              // Nothing to map into: fail before any page is taken
              if (32'(res_row) >= Rows) begin
                status_q <= khfm_pkg::STATUS_NOFRAME;
                state    <= S_DONE;
              end else begin
                state <= S_SCAN_RD;
              end
            end else begin
              pg     <= want[6:0];
              pg_end <= break_page;
              shrink <= 1'b1;
              if (want[6:0] == break_page) begin
                state <= S_DONE;
              end else begin
                state <= S_FREE_RD;
              end
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (find.found) begin
            pg <= pg_inc;
            if (pg_inc == pg_end) begin
              break_page <= pg_end;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN_RD;
            end
          end else if (32'(scan_row) == Rows - 1) begin
            // Out of frames: undo the pages mapped so far by this request
            status_q <= khfm_pkg::STATUS_NOFRAME;
            shrink   <= 1'b0;
            pg       <= break_page;
            pg_end   <= pg;
            if (pg == break_page) begin
              state <= S_DONE;
            end else begin
              state <= S_FREE_RD;
            end
          end else begin
            scan_row <= scan_row + RowW'(1);
            state    <= S_SCAN_RD;
          end
        end
        S_FREE_RD: begin
          // Pages beyond the table hold nothing; drop the rest of the walk
          if (32'(pg) >= TABLE_PAGES) begin
            if (shrink) begin
              break_page <= np_q;
            end
            state <= S_DONE;
          end else begin
            state <= S_FREE_FRM;
          end
        end
        S_FREE_FRM: begin
          if (pt_rd_valid) begin
            state <= S_FREE_WR;
          end else begin
            pg <= pg_inc;
            if (pg_inc == pg_end) begin
              if (shrink) begin
                break_page <= np_q;
              end
              state <= S_DONE;
            end else begin
              state <= S_FREE_RD;
            end
          end
        end
        S_FREE_WR: begin
          pg <= pg_inc;
          if (pg_inc == pg_end) begin
            if (shrink) begin
              break_page <= np_q;
            end
            state <= S_DONE;
          end else begin
            state <= S_FREE_RD;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  khfm_frame_map #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_frame_map (
    .clk            (clk),
    .rd_addr        (fm_rd_addr),
    .rd_data        (fm_rd_data),
    .wr_en          (fm_wr_en),
    .wr_addr        (fm_wr_addr),
    .wr_data        (fm_wr_data),
    .reserved_frames(reserved),
    .find           (find)
  );

  khfm_page_table #(
    .TABLE_PAGES(TABLE_PAGES),
    .FRAME_COUNT(FRAME_COUNT)
  ) u_page_table (
    .clk     (clk),
    .rd_addr (pt_addr),
    .rd_valid(pt_rd_valid),
    .rd_frame(pt_rd_frame),
    .wr_addr (pt_wr_addr),
    .valid_we(pt_valid_we),
    .valid_wd(pt_valid_wd),
    .frame_we(pt_frame_we),
    .frame_wd(pt_frame_wd)
  );

endmodule

// ===== test/tb_kernel_heap_frame_mapper_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for kernel_heap_frame_mapper_top: break requests, frame map.
// Depends on khfm_pkg and the RTL of the block; a scoreboard class predicts each result.
module tb_kernel_heap_frame_mapper_top;

  localparam int FRAME_COUNT    = 512;
  localparam int TABLE_PAGES    = 128;
  localparam int PAGE_SHIFT     = 13;
  localparam int PAGE_BYTES     = 1 << PAGE_SHIFT;
  localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_SHIFT) - 33'd1;
  localparam int PHASE_ITEMS    = 119;
  localparam int RANDOM_ITEMS   = 8 * PHASE_ITEMS;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] brk;
    logic       flush;
  } break_result_t;

  class heap_break_scoreboard;
    bit            frame_used [FRAME_COUNT];
    bit            page_valid [TABLE_PAGES];
    logic [8:0]    page_frame [TABLE_PAGES];
    logic [6:0]    brk;
    logic [6:0]    stack_base;
    logic          paging;
    logic [6:0]    heap_start;
    logic [9:0]    reserved;
    break_result_t expected_q [$];
    int            errors;

    function new();
      for (int i = 0; i < FRAME_COUNT; i++) frame_used[i] = 1'b0;
      for (int i = 0; i < TABLE_PAGES; i++) begin
        page_valid[i] = 1'b0;
        page_frame[i] = '0;
      end
      stack_base = 7'd126;
      paging     = 1'b0;
      heap_start = 7'd0;
      reserved   = 10'd0;
      brk        = heap_start;
      errors     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] data);
      case (idx)
        khfm_pkg::CFG_STACK_BASE: stack_base = data[6:0];
        khfm_pkg::CFG_PAGING:     paging = data[0];
        khfm_pkg::CFG_HEAP_START: begin
          heap_start = data[6:0];
          brk = data[6:0];
        end
        khfm_pkg::CFG_RESERVED:   reserved = data;
        default: ;
      endcase
    endfunction

    // Lowest free frame at or above the reserved count, -1 when none.
    function int free_frame();
      for (int f = int'(reserved); f < FRAME_COUNT; f++)
        if (!frame_used[f]) return f;
      return -1;
    endfunction

    function void note_request(logic [31:0] addr);
      int unsigned   want;
      int            cur;
      int            np;
      int            f;
      break_result_t r;
      want = 32'(({1'b0, addr} + PAGE_MASK) >> PAGE_SHIFT);
      r.status = khfm_pkg::STATUS_OK;
      r.flush = 1'b0;
      if (want >= stack_base || want >= TABLE_PAGES) begin
        r.status = khfm_pkg::STATUS_COLLIDE;
      end else if (!paging) begin
        brk = 7'(want);
      end else begin
        np = int'(want);
        cur = int'(brk);
        r.flush = 1'b1;
        if (np > cur) begin
          for (int i = cur; i < np && r.status == khfm_pkg::STATUS_OK; i++) begin
            f = free_frame();
            if (f < 0) begin
              // undo the pages mapped by this request
              for (int j = cur; j < i; j++) begin
                frame_used[page_frame[j]] = 1'b0;
                page_valid[j] = 1'b0;
              end
              r.status = khfm_pkg::STATUS_NOFRAME;
            end else begin
              frame_used[f] = 1'b1;
              page_valid[i] = 1'b1;
              page_frame[i] = 9'(f);
            end
          end
          if (r.status == khfm_pkg::STATUS_OK) brk = 7'(np);
        end else begin
          for (int i = np; i < cur; i++) begin
            if (i < TABLE_PAGES && page_valid[i]) begin
              frame_used[page_frame[i]] = 1'b0;
              page_valid[i] = 1'b0;
            end
          end
          brk = 7'(np);
        end
      end
      r.brk = brk;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [6:0] bp, logic fl);
      break_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: status %0d break %0d flush %0d",
                   $realtime, st, bp, fl);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || bp !== e.brk || fl !== e.flush) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch (exp/got): status %0d/%0d break %0d/%0d flush %0d/%0d",
                   $realtime, e.status, st, e.brk, bp, e.flush, fl);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] new_break_addr = '0;
  logic        done;
  logic [1:0]  status;
  logic [6:0]  break_page_now;
  logic        flush_request;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = khfm_pkg::CFG_STACK_BASE;
  logic [9:0]  cfg_data = '0;

  heap_break_scoreboard sb;
  int rand_count = 0;
  int idle_cycles = 0;

  kernel_heap_frame_mapper_top #(
    .FRAME_COUNT(FRAME_COUNT),
    .TABLE_PAGES(TABLE_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .new_break_addr(new_break_addr),
    .done          (done),
    .status        (status),
    .break_page_now(break_page_now),
    .flush_request (flush_request),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results first: a result is always older than a request taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, break_page_now, flush_request);
      if (start && !busy) sb.note_request(new_break_addr);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_kernel_heap_frame_mapper_top: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] page_addr(int p);
    return 32'(p) << PAGE_SHIFT;
  endfunction

  // Mostly small moves around the current break, some jumps, some probes at the stack.
  function automatic logic [31:0] pick_break();
    int r;
    int d;
    int p;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      d = $urandom_range(0, 12);
      p = int'(sb.brk) + d - 6;
    end else if (r < 82) begin
      p = $urandom_range(0, TABLE_PAGES - 1);
    end else if (r < 92) begin
      d = $urandom_range(0, 2);
      p = int'(sb.stack_base) + d - 1;
    end else begin
      return $urandom();
    end
    if (p < 0) p = 0;
    if (p > TABLE_PAGES - 1) p = TABLE_PAGES - 1;
    if (p == 0) return '0;
    return page_addr(p) - 32'($urandom_range(0, PAGE_BYTES - 1));
  endfunction

  task automatic send_request(input logic [31:0] addr, input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    new_break_addr <= addr;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop start and hold until every request has returned its result.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input int stack, input int pg, input int heap, input int res);
    drain();
    write_reg(khfm_pkg::CFG_STACK_BASE, 10'(stack));
    write_reg(khfm_pkg::CFG_PAGING, 10'(pg));
    write_reg(khfm_pkg::CFG_RESERVED, 10'(res));
    write_reg(khfm_pkg::CFG_HEAP_START, 10'(heap));
  endtask

  task automatic run_phase(input int count);
    int idle_pct;
    for (int n = 0; n < count; n++) begin
      if (rand_count < RANDOM_ITEMS / 3) idle_pct = 33;
      else if (rand_count < 2 * RANDOM_ITEMS / 3) idle_pct = 62;
      else idle_pct = 0;
      send_request(pick_break(), idle_pct);
      rand_count++;
    end
    // hand the heap back so that later phases start from free frames
    if (sb.paging) send_request('0, 0);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // paging off at reset settings: rounding and stack collisions
    send_request(32'd0, 0);
    send_request(32'd1, 0);
    send_request(page_addr(1), 0);
    send_request(page_addr(1) + 32'd1, 0);
    send_request(page_addr(125), 0);
    send_request(page_addr(125) + 32'd1, 0);
    send_request(32'hFFFF_FFFF, 0);
    send_request(32'hFFFF_E001, 0);

    // paging on: grow, same page, shrink, full heap
    configure(126, 1, 0, 0);
    send_request(page_addr(3), 0);
    send_request(page_addr(3), 0);
    send_request(page_addr(10), 0);
    send_request(page_addr(2), 0);
    send_request(32'd0, 0);
    send_request(page_addr(126), 0);
    send_request(page_addr(125), 0);
    send_request(32'd0, 0);

    // three frames left: growth runs out and is undone
    configure(126, 1, 0, 509);
    send_request(page_addr(2), 0);
    send_request(page_addr(6), 0);
    send_request(page_addr(3), 0);
    send_request(32'd0, 0);

    // no frame at all
    configure(126, 1, 0, 512);
    send_request(32'd1, 0);
    send_request(32'd0, 0);

    // move the break under valid pages, then grow over them
    configure(126, 1, 0, 0);
    send_request(page_addr(8), 0);
    drain();
    write_reg(khfm_pkg::CFG_HEAP_START, 10'd2);
    send_request(page_addr(6), 0);
    send_request(32'd0, 0);

    configure(126, 1, 0, 0);
    run_phase(PHASE_ITEMS);
    configure(127, 1, 0, 500);
    run_phase(PHASE_ITEMS);
    configure(64, 0, 10, 0);
    run_phase(PHASE_ITEMS);
    configure(100, 1, 3, 511);
    run_phase(PHASE_ITEMS);
    configure(0, 1, 0, 0);
    run_phase(PHASE_ITEMS);
    configure(127, 1, 127, 0);
    run_phase(PHASE_ITEMS);
    configure(126, 1, 5, 512);
    run_phase(PHASE_ITEMS);
    configure(126, 1, 0, 300);
    run_phase(PHASE_ITEMS);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_kernel_heap_frame_mapper_top: clean");
    end else begin
      $display("tb_kernel_heap_frame_mapper_top: errors");
    end
    $finish;
  end

endmodule
